// ===== src/u8d_pkg.sv =====
// ----------------------------------------------------------------------------
// u8d_pkg: shared types and constants of the UTF-8 code point decoder
// Byte classification masks, status codes and the result record that travels
// from the decode core to the result register.
// ----------------------------------------------------------------------------
package u8d_pkg;

	localparam int unsigned CP_W = 21;

	// Result status codes.
	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_BAD_LEAD  = 2'd1,
		STATUS_BAD_CONT  = 2'd2,
		STATUS_TRUNCATED = 2'd3
	} status_t;

	// Lead and continuation byte masks and patterns.
	localparam logic [7:0] ASCII_LIMIT  = 8'h80;
	localparam logic [7:0] LEAD2_MASK   = 8'hE0;
	localparam logic [7:0] LEAD2_PAT    = 8'hC0;
	localparam logic [7:0] LEAD2_BITS   = 8'h1F;
	localparam logic [7:0] LEAD3_MASK   = 8'hF0;
	localparam logic [7:0] LEAD3_PAT    = 8'hE0;
	localparam logic [7:0] LEAD3_BITS   = 8'h0F;
	localparam logic [7:0] LEAD4_MASK   = 8'hF8;
	localparam logic [7:0] LEAD4_PAT    = 8'hF0;
	localparam logic [7:0] LEAD4_BITS   = 8'h07;
	localparam logic [7:0] CONT_MASK    = 8'hC0;
	localparam logic [7:0] CONT_PAT     = 8'h80;
	localparam logic [7:0] CONT_BITS    = 8'h3F;

	// One decoded result.
	typedef struct packed {
		logic [CP_W-1:0] code_point;
		status_t         status;
		logic            last_of_text;
	} result_t;

endpackage

// ===== src/u8d_if.sv =====
// ----------------------------------------------------------------------------
// u8d_if: stream channels of the UTF-8 code point decoder
// A byte channel into the decoder and a code point channel out of it, each
// with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface u8d_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       end_of_text;

	modport source (output valid, output data_byte, output end_of_text, input ready);
	modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface u8d_point_if;
	logic        valid;
	logic        ready;
	logic [20:0] code_point;
	logic [1:0]  status;
	logic        last_of_text;

	modport source (output valid, output code_point, output status, output last_of_text,
		input ready);
	modport sink   (input valid, input code_point, input status, input last_of_text,
		output ready);
endinterface

// ===== src/utf8_code_point_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// utf8_code_point_decoder_unit: streaming UTF-8 to code point decoder
// Registers each text byte, decodes it against the running sequence state
// and registers the code point and status when a sequence completes.
// ----------------------------------------------------------------------------
//  channel  | dir | payload                                  | per transaction
//  ---------+-----+------------------------------------------+----------------
//  bytes    | in  | data_byte[7:0], end_of_text              | one text byte
//  points   | out | code_point[20:0], status[1:0], last_of_t | zero or one result
//
//  One byte is accepted per cycle unless the output stalls; the byte that
//  completes a result passes the input register, then the result register.
//  The loop through the sequence state register sets that rate.
//  A result held by a stalled sink stops the byte register, and ready drops
//  only when both registers are full and the sink is not ready.
//  Reset clears both valid flags and returns the decoder to idle.
module utf8_code_point_decoder_unit (
	input  logic               clk,
	input  logic               arst_n,
	u8d_byte_if.sink           bytes,
	u8d_point_if.source        points
);

	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             eot_s1;
	logic             valid_s2;
	u8d_pkg::result_t res_s2;

	logic             res_valid;
	u8d_pkg::result_t res;
	logic             out_free;
	logic             adv_s1;

	// Stage 1 moves on whenever the result register can take its outcome.
	assign out_free     = !valid_s2 || points.ready;
	assign adv_s1       = valid_s1 && out_free;
	assign bytes.ready  = !valid_s1 || out_free;

	// Input byte register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			byte_s1 <= bytes.data_byte;
			eot_s1  <= bytes.end_of_text;
		end
	end

	// Decode core with the sequence state.
	u8d_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step_en     (adv_s1),
		.data_byte   (byte_s1),
		.end_of_text (eot_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (out_free) begin
			valid_s2 <= adv_s1 && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && res_valid) begin
			res_s2 <= res;
		end
	end

	assign points.valid        = valid_s2;
	assign points.code_point   = res_s2.code_point;
	assign points.status       = res_s2.status;
	assign points.last_of_text = res_s2.last_of_text;

	// Any error result carries a zero code point.
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.status != u8d_pkg::STATUS_OK) |-> (res_s2.code_point == '0))
		else $error("error result with nonzero code point");

	// A truncated result always marks the end of the text.
	a_trunc_last: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.status == u8d_pkg::STATUS_TRUNCATED) |-> res_s2.last_of_text)
		else $error("truncated result without end of text");

	// An empty byte register never blocks the input.
	a_empty_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> bytes.ready)
		else $error("input stalled with empty byte register");

	// A stalled result cannot be overwritten by a new byte's outcome.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !points.ready) |=> (valid_s2 && res_s2 == $past(res_s2)))
		else $error("pending result overwritten");

endmodule

// ===== src/u8d_core.sv =====
// ----------------------------------------------------------------------------
// u8d_core: sequence state and single-byte decode step
// Holds the continuation count, the partial code point and the bad
// continuation mark, and decides per byte whether a result is due.
// ----------------------------------------------------------------------------
module u8d_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step_en,
	input  logic [7:0]       data_byte,
	input  logic             end_of_text,
	output logic             res_valid,
	output u8d_pkg::result_t res
);

	logic [1:0]                 owed_q;
	logic [u8d_pkg::CP_W-1:0]   part_q;
	logic                       bad_q;

	logic [1:0]                 owed_d;
	logic [u8d_pkg::CP_W-1:0]   part_d;
	logic                       bad_d;
	logic [u8d_pkg::CP_W-1:0]   shifted;
	logic                       bad_acc;
	logic [1:0]                 owed_dec;

	// Continuation path values, used whenever bytes are owed.
	assign shifted  = {part_q[u8d_pkg::CP_W-7:0], data_byte[5:0]};
	assign bad_acc  = bad_q | ((data_byte & u8d_pkg::CONT_MASK) != u8d_pkg::CONT_PAT);
	assign owed_dec = owed_q - 2'd1;

	// Decode one byte against the current sequence state.
	always_comb begin
		owed_d           = owed_q;
		part_d           = part_q;
		bad_d            = bad_q;
		res_valid        = 1'b0;
		res.code_point   = '0;
		res.status       = u8d_pkg::STATUS_OK;
		res.last_of_text = end_of_text;
		if (owed_q == 2'd0) begin
			priority if (data_byte < u8d_pkg::ASCII_LIMIT) begin
				res_valid      = 1'b1;
				res.code_point = {{(u8d_pkg::CP_W-8){1'b0}}, data_byte};
			end else if ((data_byte & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_PAT) begin
				owed_d = 2'd1;
				part_d = {{(u8d_pkg::CP_W-8){1'b0}}, data_byte & u8d_pkg::LEAD2_BITS};
				bad_d  = 1'b0;
			end else if ((data_byte & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_PAT) begin
				owed_d = 2'd2;
				part_d = {{(u8d_pkg::CP_W-8){1'b0}}, data_byte & u8d_pkg::LEAD3_BITS};
				bad_d  = 1'b0;
			end else if ((data_byte & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_PAT) begin
				owed_d = 2'd3;
				part_d = {{(u8d_pkg::CP_W-8){1'b0}}, data_byte & u8d_pkg::LEAD4_BITS};
				bad_d  = 1'b0;
			end else begin
				res_valid  = 1'b1;
				res.status = u8d_pkg::STATUS_BAD_LEAD;
			end
			// A lead byte that ends the text leaves the sequence cut short.
			if (!res_valid && end_of_text) begin
				owed_d     = 2'd0;
				part_d     = '0;
				bad_d      = 1'b0;
				res_valid  = 1'b1;
				res.status = u8d_pkg::STATUS_TRUNCATED;
			end
		end else begin
			owed_d = owed_dec;
			part_d = shifted;
			bad_d  = bad_acc;
			if (owed_dec == 2'd0) begin
				owed_d    = 2'd0;
				part_d    = '0;
				bad_d     = 1'b0;
				res_valid = 1'b1;
				if (bad_acc) begin
					res.status = u8d_pkg::STATUS_BAD_CONT;
				end else begin
					res.code_point = shifted;
				end
			end else if (end_of_text) begin
				owed_d     = 2'd0;
				part_d     = '0;
				bad_d      = 1'b0;
				res_valid  = 1'b1;
				res.status = u8d_pkg::STATUS_TRUNCATED;
			end
		end
	end

	// Sequence state advances once per processed byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owed_q <= 2'd0;
			part_q <= '0;
			bad_q  <= 1'b0;
		end else if (step_en) begin
			owed_q <= owed_d;
			part_q <= part_d;
			bad_q  <= bad_d;
		end
	end

endmodule
